@@ sv/b2d_pkg.sv @@
// ----------------------------------------------------------------------------
// b2d_pkg: shared types and constants for the decimal text converter
// Holds the converted width, the derived digit count and the control struct
// that the sequencer hands to every digit cell.
// ----------------------------------------------------------------------------
package b2d_pkg;

	// Width of the input field as seen on the port.
	localparam int VALUE_W = 32;

	// Number of bits actually converted (the rest of the input is ignored).
	localparam int VALUE_BITS = 32;

	// Decimal digits needed for the largest value: floor(bits * log10(2)) + 1.
	localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;

	localparam int BIT_CNT_W = $clog2(VALUE_BITS);
	localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);

	localparam int CHAR_W = 6;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);

	// Per-cycle command for the row of digit cells.
	typedef struct packed {
		logic clear;   // zero the digit
		logic dabble;  // add-3 correction and shift in one binary bit
		logic shift;   // move digits one place toward the top for output
	} b2d_cell_ctrl_t;

endpackage

@@ sv/binary_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned binary to decimal ASCII digits
// Converts one unsigned number per item with a row of double-dabble digit
// cells and emits its decimal digits as ASCII, most significant first.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; the low VALUE_BITS bits
// of value are converted. The block then stays busy through double dabble (one
// binary bit enters the digit row per cycle) followed by readout (one digit
// leaves the top of the row per cycle), and it takes no new item while busy.
// During readout, leading zero digits are dropped silently; every other digit
// appears for exactly one cycle with strobe high, digit_char holding its ASCII
// code, and last high on the final digit. A value of zero produces the single
// digit '0'. The receiver cannot stall the output: each strobed digit must be
// captured in the cycle it appears. The last digit is presented in the cycle
// after busy falls, and a new item may already be accepted in that cycle.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [b2d_pkg::VALUE_W-1:0] value,
	output logic                        strobe,
	output logic [b2d_pkg::CHAR_W-1:0]  digit_char,
	output logic                        last
);
	import b2d_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]            state_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;
	logic [DIG_CNT_W-1:0]  rem_q;
	logic                  seen_q;
	logic                  strobe_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;

	b2d_cell_ctrl_t        cell_ctrl;
	logic                  accept;
	logic [3:0]            digits [NUM_DIGITS];
	logic                  carries [NUM_DIGITS];
	logic [3:0]            top_digit;
	logic                  emit_now;
	logic                  final_digit;

	assign accept      = start && (state_q == ST_IDLE);
	assign busy        = (state_q != ST_IDLE);
	assign top_digit   = digits[NUM_DIGITS-1];
	assign final_digit = (rem_q == DIG_CNT_W'(1));

	// A digit is shown once a nonzero digit has appeared, or when it is the
	// units digit, which is always shown so that zero reads as '0'.
	assign emit_now = (state_q == ST_EMIT) &&
		(seen_q || (top_digit != 4'd0) || final_digit);

	assign cell_ctrl.clear  = accept;
	assign cell_ctrl.dabble = (state_q == ST_CONV);
	assign cell_ctrl.shift  = (state_q == ST_EMIT);

	// The row of digit cells: cell 0 is the units digit. During conversion each
	// cell shifts in the corrected top bit of its lower neighbor; during readout
	// each cell takes its lower neighbor's digit and the top cell is presented.
	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		b2d_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl),
			.carry_in ((i == 0) ? bin_q[VALUE_BITS-1] : carries[(i == 0) ? 0 : i-1]),
			.digit_in ((i == 0) ? 4'd0 : digits[(i == 0) ? 0 : i-1]),
			.carry_out(carries[i]),
			.digit    (digits[i])
		);
	end

	// Sequencer: load, VALUE_BITS dabble steps, then NUM_DIGITS readout steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			rem_q     <= '0;
			seen_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_CONV;
						bit_cnt_q <= BIT_CNT_W'(VALUE_BITS - 1);
						seen_q    <= 1'b0;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
					if (bit_cnt_q == '0) begin
						state_q <= ST_EMIT;
						rem_q   <= DIG_CNT_W'(NUM_DIGITS);
					end
				end
				ST_EMIT: begin
					rem_q <= rem_q - DIG_CNT_W'(1);
					if (emit_now) begin
						seen_q <= 1'b1;
					end
					if (final_digit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Binary shift register feeding the units cell, most significant bit first.
	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= VALUE_BITS'(value);
		end else if (state_q == ST_CONV) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	// Output register: each digit is presented for a single cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit_now;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_now) begin
			char_q <= CHAR_ZERO + {{(CHAR_W-4){1'b0}}, top_digit};
			last_q <= final_digit;
		end
	end

	assign strobe     = strobe_q;
	assign digit_char = char_q;
	assign last       = last_q;

endmodule

@@ sv/b2d_cell.sv @@
// ----------------------------------------------------------------------------
// b2d_cell: one BCD digit of the double-dabble row
// Holds a single decimal digit, applies the add-3 correction while the binary
// value is shifted in, and passes its digit upward while the result is read out.
// ----------------------------------------------------------------------------
module b2d_cell (
	input  logic                    clk,
	input  b2d_pkg::b2d_cell_ctrl_t ctrl,
	input  logic                    carry_in,
	input  logic [3:0]              digit_in,
	output logic                    carry_out,
	output logic [3:0]              digit
);
	import b2d_pkg::*;

	logic [3:0] digit_q;
	logic [3:0] adj;

	// Correct digits of five or more so that the following shift carries properly.
	assign adj       = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
	assign carry_out = adj[3];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= 4'd0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[2:0], carry_in};
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
		end
	end

endmodule

@@ sv/b2d_checker.sv @@
// ----------------------------------------------------------------------------
// b2d_checker: port-level checks for the decimal text converter
// Watches the start/busy handshake and the strobed digit stream over time.
// ----------------------------------------------------------------------------
module b2d_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        strobe,
	input logic [b2d_pkg::CHAR_W-1:0]  digit_char,
	input logic                        last
);
	import b2d_pkg::*;

	// Every strobed character is an ASCII decimal digit.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (digit_char >= CHAR_ZERO) && (digit_char <= CHAR_ZERO + CHAR_W'(9)))
		else $error("strobed character is not a decimal digit");

	// An accepted item keeps the block busy in the following cycle.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after accepting an item");

	// Once digits start, they follow back to back until the last one.
	a_run_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> strobe)
		else $error("gap inside a digit run");

	// A digit that is not the last one can only appear while the item is in work.
	a_mid_digit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy)
		else $error("non-final digit while idle");

	// The final digit arrives just as the block goes idle.
	a_last_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> $past(busy))
		else $error("final digit without a preceding busy cycle");

endmodule

bind binary_to_decimal_ascii b2d_checker u_b2d_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.digit_char(digit_char),
	.last      (last)
);

@@ sim/binary_to_decimal_ascii_test.sv @@
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_test: self-checking bench for the decimal text block
// Feeds unsigned numbers through the start/busy handshake, predicts each one's
// decimal digits and checks every strobed ASCII digit and its last flag.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_test;

	timeunit 1ns;
	timeprecision 1ps;

	import b2d_pkg::*;

	// Number of random items after the directed part. The final stretch of
	// them is sent with no gaps so the block runs at its full rate.
	localparam int RANDOM_ITEMS = 250;
	localparam int NO_GAP_TAIL  = 40;

	// Quiet cycles at the end: enough to cover a whole conversion, dabble and
	// readout, so this many is ample for any stray digit.
	localparam int DRAIN_CYCLES = VALUE_BITS + NUM_DIGITS + 8;

	// The slowest correct run is roughly 300 items, each one keeping the block
	// busy for a whole conversion; an idle gap ends while the block is still
	// busy. The limit is many times that.
	localparam int CYCLE_LIMIT = 200000;

	// One expected character of the output text.
	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last;
	} digit_t;

	// Holds the digits still owed by the block, oldest first, and compares
	// each strobed digit against the head of that queue.
	class decimal_text_board;
		digit_t pending_digits[$];
		int     values_noted;
		int     digits_checked;
		int     mismatches;
		int     run_length_hits[1:20];

		// Works out the decimal text of one accepted value and queues it.
		function void note_value(logic [VALUE_W-1:0] raw);
			bit [63:0]   v;
			int unsigned digits[$];
			digit_t      e;

			v = 64'(raw);
			if (VALUE_BITS < 64)
				v &= (64'd1 << VALUE_BITS) - 64'd1;
			// Peel digits off the low end; pushing to the front leaves the
			// most significant one at index zero. Zero still yields one digit.
			do begin
				digits.push_front(int'(v % 64'd10));
				v = v / 64'd10;
			end while (v != 64'd0);
			foreach (digits[k]) begin
				e.char_code = CHAR_W'(48 + digits[k]);
				e.last      = (k == digits.size() - 1);
				pending_digits.push_back(e);
			end
			run_length_hits[digits.size()]++;
			values_noted++;
		endfunction

		// Compares one strobed digit with the oldest outstanding one.
		function void check_digit(logic [CHAR_W-1:0] char_code, logic last);
			digit_t e;

			digits_checked++;
			if (pending_digits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t: unexpected digit char=%0d last=%0b with nothing pending",
						$realtime, char_code, last);
				return;
			end
			e = pending_digits.pop_front();
			if (char_code !== e.char_code || last !== e.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t: digit mismatch: expected char=%0d last=%0b, got char=%0d last=%0b",
						$realtime, e.char_code, e.last, char_code, last);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [VALUE_W-1:0]  value = '0;
	logic                busy;
	logic                strobe;
	logic [CHAR_W-1:0]   digit_char;
	logic                last;

	decimal_text_board   board = new();
	int                  cycles = 0;

	binary_to_decimal_ascii i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.strobe     (strobe),
		.digit_char (digit_char),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost digit ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Observer. Everything is sampled at the rising edge, so it sees the values
	// that were stable during the cycle that this edge ends. The block's outputs
	// cannot be held off, so every strobed digit is taken on the spot.
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				board.check_digit(digit_char, last);
			if (start && !busy)
				board.note_value(value);
		end
	end

	// Powers of ten, used to build values with a chosen number of digits.
	function automatic longint unsigned ten_to(int n);
		longint unsigned p;

		p = 1;
		repeat (n) p = p * 10;
		return p;
	endfunction

	// Random values are spread over every text length rather than left to
	// pile up at ten digits, and some are round numbers whose inner zeros must
	// survive the leading-zero suppression.
	function automatic logic [VALUE_W-1:0] random_value();
		int              n;
		longint unsigned lo;
		longint unsigned hi;

		case ($urandom_range(0, 3))
			0: begin
				return $urandom;
			end
			1: begin
				n  = $urandom_range(1, 10);
				lo = (n == 1) ? 0 : ten_to(n - 1);
				hi = (n == 10) ? 64'hFFFF_FFFF : ten_to(n) - 1;
				return VALUE_W'(lo + (longint'($urandom) % (hi - lo + 1)));
			end
			2: begin
				n = $urandom_range(0, 8);
				return VALUE_W'(ten_to(n) * $urandom_range(1, 42) + $urandom_range(0, 9));
			end
			default: begin
				return $urandom_range(0, 99);
			end
		endcase
	endfunction

	// Presents one value and holds it until the block takes it. The task
	// returns at the edge where the item was accepted, with start still high,
	// so a following item can go out back to back with no dead cycle.
	task automatic send_value(input logic [VALUE_W-1:0] v);
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
	endtask

	// Drops start for a short random stretch and puts junk on the value port,
	// which the block must ignore while start is low.
	task automatic idle_burst();
		start <= 1'b0;
		value <= $urandom;
		repeat ($urandom_range(1, 7)) @(posedge clk);
	endtask

	initial begin
		logic [VALUE_W-1:0] directed[$];
		int                 lengths_seen;

		// Extremes of the field, zero, every transition in text length near the
		// ends of the range, alternating bit patterns, and values with inner
		// zeros that must not be taken for leading ones.
		directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
			32'd10000, 32'd65535, 32'd65536, 32'd999999999, 32'd1000000000,
			32'd1000000001, 32'd2147483647, 32'd2147483648, 32'h5555_5555,
			32'hAAAA_AAAA, 32'd4000000000, 32'd4294967290, 32'd4294967294,
			32'hFFFF_FFFF};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_value(directed[i]);
			if ($urandom_range(0, 2) == 0)
				idle_burst();
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			send_value(random_value());
			if (i < RANDOM_ITEMS - NO_GAP_TAIL && $urandom_range(0, 2) == 0)
				idle_burst();
		end
		start <= 1'b0;

		// Let the last conversion finish, then keep watching for a while in
		// case the block emits something it was never asked for.
		while (board.pending_digits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		lengths_seen = 0;
		for (int n = 1; n <= NUM_DIGITS; n++)
			if (board.run_length_hits[n] != 0)
				lengths_seen++;
		$display("Converted %0d values into %0d checked digits, %0d mismatches.",
			board.values_noted, board.digits_checked, board.mismatches);
		$display("Text lengths exercised: %0d of %0d possible.", lengths_seen, NUM_DIGITS);

		if (board.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
